// ===== src/tea_pkg.sv =====
// tea_pkg: shared constants, types and round functions of the tea block cipher
// no dependencies; used by the interfaces and all tea modules
`timescale 1ns / 1ps
`default_nettype none

package tea_pkg;

  // cipher constants
  localparam int unsigned ROUND_PAIRS = 32;
  localparam int unsigned WORD_W      = 32;
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E3779B9;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 8'd3;

  // direction codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // 128-bit key as four words, word 0 in the low slot
  typedef logic [3:0][WORD_W-1:0] tea_key_t;

  // block travelling down the pipeline
  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
  } tea_blk_t;

  // result word
  typedef struct packed {
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
  } tea_res_t;

  // feistel mixing term
  function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] x,
                                                input logic [WORD_W-1:0] sum,
                                                input logic [WORD_W-1:0] ka,
                                                input logic [WORD_W-1:0] kb);
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

  // running sum of round pair n when encrypting: (n + 1) * delta
  function automatic logic [WORD_W-1:0] tea_enc_sum(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(n + 1) * 64'(TEA_DELTA);
    return prod[WORD_W-1:0];
  endfunction

  // running sum of round pair n when decrypting: (ROUND_PAIRS - n) * delta
  function automatic logic [WORD_W-1:0] tea_dec_sum(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(ROUND_PAIRS - n) * 64'(TEA_DELTA);
    return prod[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/tea_if.sv =====
// tea_in_if, tea_out_if, tea_cfg_if: valid/ready channels of the tea block cipher
// depends on tea_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

// block input channel
interface tea_in_if import tea_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [WORD_W-1:0] block_left;
  logic [WORD_W-1:0] block_right;

  modport source (output valid, output op, output block_left, output block_right,
                  input ready);
  modport sink (input valid, input op, input block_left, input block_right,
                output ready);
endinterface

// result output channel
interface tea_out_if import tea_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result_left;
  logic [WORD_W-1:0] result_right;

  modport source (output valid, output result_left, output result_right, input ready);
  modport sink (input valid, input result_left, input result_right, output ready);
endinterface

// key register write channel
interface tea_cfg_if import tea_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/tea_block_cipher.sv =====
// tea_block_cipher: fully pipelined tea encrypt/decrypt core, one round pair per stage
// depends on tea_pkg, tea_if, tea_round and tea_obuf
//
//   port    dir   role              word
//   cfg_i   in    key register      index, data (32-bit key word)
//   in_i    in    block input       op, block_left, block_right
//   out_o   out   result output     result_left, result_right
//
// a block passes through the round stages, one per round pair, and then the output buffer
// one block is accepted every cycle while the output buffer has room
// the whole pipeline advances together; it holds when the two-entry output buffer is full
// reset clears the key words and all stage valid bits; key writes are always accepted
`timescale 1ns / 1ps
`default_nettype none

module tea_block_cipher import tea_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tea_cfg_if.sink   cfg_i,
  tea_in_if.sink    in_i,
  tea_out_if.source out_o
);

  tea_key_t key_q;
  logic     en;
  logic     buf_full;
  logic     valid [ROUND_PAIRS+1];
  tea_blk_t blk   [ROUND_PAIRS+1];
  tea_res_t res;

  // key register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_KEY_WORD_0: key_q[0] <= cfg_i.data;
        CFG_KEY_WORD_1: key_q[1] <= cfg_i.data;
        CFG_KEY_WORD_2: key_q[2] <= cfg_i.data;
        CFG_KEY_WORD_3: key_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline advance
  assign en         = !buf_full;
  assign in_i.ready = en;

  // pipeline entry
  assign valid[0]     = in_i.valid;
  assign blk[0].op    = in_i.op;
  assign blk[0].left  = in_i.block_left;
  assign blk[0].right = in_i.block_right;

  // round pair stages
  for (genvar n = 0; n < ROUND_PAIRS; n++) begin : g_round
    tea_round u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (valid[n]),
      .blk_i     (blk[n]),
      .sum_enc_i (tea_enc_sum(n)),
      .sum_dec_i (tea_dec_sum(n)),
      .key_i     (key_q),
      .valid_o   (valid[n+1]),
      .blk_o     (blk[n+1])
    );
  end

  // result into the output buffer
  assign res.left  = blk[ROUND_PAIRS].left;
  assign res.right = blk[ROUND_PAIRS].right;

  tea_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (en && valid[ROUND_PAIRS]),
    .res_i  (res),
    .full_o (buf_full),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ===== src/tea_round.sv =====
// tea_round: one pipeline stage doing one round pair, encrypt or decrypt
// depends on tea_pkg
`timescale 1ns / 1ps
`default_nettype none

module tea_round import tea_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  tea_blk_t          blk_i,
  input  logic [WORD_W-1:0] sum_enc_i,
  input  logic [WORD_W-1:0] sum_dec_i,
  input  tea_key_t          key_i,
  output logic              valid_o,
  output tea_blk_t          blk_o
);

  logic [WORD_W-1:0] enc_left, enc_right;
  logic [WORD_W-1:0] dec_left, dec_right;
  tea_blk_t          blk_d, blk_q;
  logic              valid_q;

  // encrypt: left first, then right with the new left
  always_comb begin
    enc_left  = blk_i.left + tea_mix(blk_i.right, sum_enc_i, key_i[0], key_i[1]);
    enc_right = blk_i.right + tea_mix(enc_left, sum_enc_i, key_i[2], key_i[3]);
  end

  // decrypt: undo right first, then left with the restored right
  always_comb begin
    dec_right = blk_i.right - tea_mix(blk_i.left, sum_dec_i, key_i[2], key_i[3]);
    dec_left  = blk_i.left - tea_mix(dec_right, sum_dec_i, key_i[0], key_i[1]);
  end

  // direction select
  always_comb begin
    blk_d.op = blk_i.op;
    if (blk_i.op == OP_DECRYPT) begin
      blk_d.left  = dec_left;
      blk_d.right = dec_right;
    end else begin
      blk_d.left  = enc_left;
      blk_d.right = enc_right;
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

`default_nettype wire

// ===== src/tea_obuf.sv =====
// tea_obuf: two-entry output buffer between the round pipeline and the result channel
// depends on tea_pkg and tea_out_if
`timescale 1ns / 1ps
`default_nettype none

module tea_obuf import tea_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  tea_res_t  res_i,
  output logic      full_o,
  tea_out_if.source out_o
);

  tea_res_t    mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        rd;

  assign rd = out_o.valid && out_o.ready;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!wr_i && rd) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i) begin
        wptr_q <= ~wptr_q;
      end
      if (rd) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= res_i;
    end
  end

  assign full_o             = cnt_q[1];
  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.result_left  = mem_q[rptr_q].left;
  assign out_o.result_right = mem_q[rptr_q].right;

endmodule

`default_nettype wire
